>>> hdl/phtab_pkg.sv
// ----------------------------------------------------------------------------
// Page address hash table package
// Shared constants, codes and types for the page address hash table.
// ----------------------------------------------------------------------------
package phtab_pkg;

    localparam int CAP_LOG2   = 10;
    localparam int PAGE_SHIFT = 12;
    localparam int ADDR_BITS  = 48;
    localparam int TAG_BITS   = 16;

    localparam int CAP        = 1 << CAP_LOG2;
    localparam int PAGE_BITS  = ADDR_BITS - PAGE_SHIFT;
    localparam int CNT_BITS   = CAP_LOG2 + 1;
    localparam int LEN_BITS   = 16;
    localparam int LOAD_BITS  = CNT_BITS + 4;

    localparam logic [CAP_LOG2-1:0]  IDX_ONE    = CAP_LOG2'(1);
    localparam logic [CAP_LOG2-1:0]  IDX_LAST   = '1;
    localparam logic [CNT_BITS-1:0]  CNT_ONE    = CNT_BITS'(1);
    localparam logic [CNT_BITS-1:0]  CNT_CAP    = CNT_BITS'(CAP);
    localparam logic [LEN_BITS-1:0]  LEN_ONE    = LEN_BITS'(1);
    localparam logic [LEN_BITS-1:0]  LEN_ZERO   = '0;
    localparam logic [PAGE_BITS-1:0] PAGE_ONE   = PAGE_BITS'(1);
    localparam logic [LOAD_BITS-1:0] LOAD_LIMIT = LOAD_BITS'(7 * CAP);

    localparam logic       OP_LOOKUP = 1'b0;
    localparam logic       OP_INSERT = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CMP
    } t_state;

    typedef struct packed {
        logic                 valid;
        logic [PAGE_BITS-1:0] page;
        logic [TAG_BITS-1:0]  tag;
    } t_entry;

    typedef struct packed {
        logic                we;
        logic [CAP_LOG2-1:0] addr;
        t_entry              wdata;
    } t_mem_req;

endpackage

>>> hdl/page_address_hash_table.sv
// ----------------------------------------------------------------------------
// Page address hash table
// Open-addressing page-to-tag table with triangular probing over 1024 slots.
// ----------------------------------------------------------------------------
// Probe loop: each probed slot passes a read state, then a compare state.
//   Lookup: probes of one page, then the result word. Insert: probes of each
//   page in turn, then the result word. A zero-page insert skips probing.
// Throughput: one word at a time; busy stays high until the result strobe.
// Reset: synchronous; a clearing pass over all 1024 slots follows, busy meanwhile.
// Results cannot be stalled: o_strobe marks each word for one cycle.
module page_address_hash_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_op,
    input  logic [phtab_pkg::ADDR_BITS-1:0] i_address,
    input  logic [phtab_pkg::LEN_BITS-1:0]  i_page_count,
    input  logic [phtab_pkg::TAG_BITS-1:0]  i_block_tag,
    output logic                            o_strobe,
    output logic [1:0]                      o_status,
    output logic [phtab_pkg::TAG_BITS-1:0]  o_found_tag,
    output logic [phtab_pkg::LEN_BITS-1:0]  o_pages_stored,
    output logic [phtab_pkg::CNT_BITS-1:0]  o_occupancy,
    output logic                            o_load_high
);

    phtab_pkg::t_mem_req            req;
    phtab_pkg::t_entry              rd_data;
    logic [phtab_pkg::CAP_LOG2-1:0] rd_addr;
    logic [phtab_pkg::CNT_BITS-1:0] occupancy;
    logic [phtab_pkg::LOAD_BITS-1:0] load_x10;

    phtab_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_address      (i_address),
        .i_page_count   (i_page_count),
        .i_block_tag    (i_block_tag),
        .o_req          (req),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_found_tag    (o_found_tag),
        .o_pages_stored (o_pages_stored),
        .o_occupancy    (occupancy)
    );

    phtab_store u_store (
        .i_clk     (i_clk),
        .i_req     (req),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // 10 * occupancy as 8x + 2x
    assign load_x10    = {1'b0, occupancy, 3'b000} + {3'b000, occupancy, 1'b0};
    assign o_load_high = (load_x10 > phtab_pkg::LOAD_LIMIT);
    assign o_occupancy = occupancy;

endmodule

>>> hdl/phtab_store.sv
// ----------------------------------------------------------------------------
// Slot store
// Dual-port slot memory holding valid bit, page and tag; registered read.
// ----------------------------------------------------------------------------
module phtab_store (
    input  logic                          i_clk,
    input  phtab_pkg::t_mem_req           i_req,
    input  logic [phtab_pkg::CAP_LOG2-1:0] i_rd_addr,
    output phtab_pkg::t_entry             o_rd_data
);

    phtab_pkg::t_entry r_mem [phtab_pkg::CAP];
    phtab_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/phtab_ctrl.sv
// ----------------------------------------------------------------------------
// Probe sequencer
// Walks the triangular probe sequence with one shared index adder, reading
// then comparing each slot, and handles lookup, insert, full table and clearing.
// ----------------------------------------------------------------------------
module phtab_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_op,
    input  logic [phtab_pkg::ADDR_BITS-1:0] i_address,
    input  logic [phtab_pkg::LEN_BITS-1:0]  i_page_count,
    input  logic [phtab_pkg::TAG_BITS-1:0]  i_block_tag,
    output phtab_pkg::t_mem_req             o_req,
    output logic [phtab_pkg::CAP_LOG2-1:0]  o_rd_addr,
    input  phtab_pkg::t_entry               i_rd_data,
    output logic                            o_strobe,
    output logic [1:0]                      o_status,
    output logic [phtab_pkg::TAG_BITS-1:0]  o_found_tag,
    output logic [phtab_pkg::LEN_BITS-1:0]  o_pages_stored,
    output logic [phtab_pkg::CNT_BITS-1:0]  o_occupancy
);

    phtab_pkg::t_state                r_state, n_state;
    logic                             r_op, n_op;
    logic [phtab_pkg::PAGE_BITS-1:0]  r_page, n_page;
    logic [phtab_pkg::TAG_BITS-1:0]   r_tag, n_tag;
    logic [phtab_pkg::LEN_BITS-1:0]   r_remaining, n_remaining;
    logic [phtab_pkg::LEN_BITS-1:0]   r_stored, n_stored;
    logic [phtab_pkg::CAP_LOG2-1:0]   r_k, n_k;
    logic [phtab_pkg::CAP_LOG2-1:0]   r_idx, n_idx;
    logic [phtab_pkg::CNT_BITS-1:0]   r_valid_cnt, n_valid_cnt;
    logic                             r_strobe, n_strobe;
    logic [1:0]                       r_status, n_status;
    logic [phtab_pkg::TAG_BITS-1:0]   r_found, n_found;

    logic [phtab_pkg::PAGE_BITS-1:0]  in_page;
    logic [phtab_pkg::PAGE_BITS-1:0]  page_inc;
    logic [phtab_pkg::CAP_LOG2-1:0]   idx_sum;
    logic                             slot_hit;
    logic                             slot_free;
    logic                             k_last;
    logic                             last_page;
    logic                             zero_insert;
    logic                             finish;

    // shared probe adder: next triangular slot, or next slot while clearing
    assign idx_sum     = r_idx + r_k + phtab_pkg::IDX_ONE;
    assign page_inc    = r_page + phtab_pkg::PAGE_ONE;
    assign in_page     = i_address[phtab_pkg::ADDR_BITS-1:phtab_pkg::PAGE_SHIFT];
    assign slot_hit    = i_rd_data.valid && (i_rd_data.page == r_page);
    assign slot_free   = !i_rd_data.valid;
    assign k_last      = (r_k == phtab_pkg::IDX_LAST);
    assign last_page   = (r_remaining == phtab_pkg::LEN_ONE);
    assign zero_insert = (i_op == phtab_pkg::OP_INSERT) && (i_page_count == phtab_pkg::LEN_ZERO);
    assign finish      = (slot_hit || slot_free)
                         ? ((r_op == phtab_pkg::OP_LOOKUP) || last_page) : k_last;

    always_comb begin
        n_state = r_state;
        case (r_state)
            phtab_pkg::S_CLEAR: begin
                if (r_idx == phtab_pkg::IDX_LAST) begin
                    n_state = phtab_pkg::S_IDLE;
                end
            end
            phtab_pkg::S_IDLE: begin
                if (start && !zero_insert) begin
                    n_state = phtab_pkg::S_READ;
                end
            end
            phtab_pkg::S_READ: begin
                n_state = phtab_pkg::S_CMP;
            end
            phtab_pkg::S_CMP: begin
                n_state = finish ? phtab_pkg::S_IDLE : phtab_pkg::S_READ;
            end
            default: begin
                n_state = phtab_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_op        = r_op;
        n_page      = r_page;
        n_tag       = r_tag;
        n_remaining = r_remaining;
        n_stored    = r_stored;
        n_k         = r_k;
        n_idx       = r_idx;
        n_valid_cnt = r_valid_cnt;
        n_strobe    = 1'b0;
        n_status    = r_status;
        n_found     = r_found;
        o_req.we    = 1'b0;
        o_req.addr  = r_idx;
        o_req.wdata = '{valid: 1'b1, page: r_page, tag: r_tag};
        case (r_state)
            phtab_pkg::S_CLEAR: begin
                o_req.we    = 1'b1;
                o_req.wdata = '0;
                n_idx       = idx_sum;
            end
            phtab_pkg::S_IDLE: begin
                if (start) begin
                    n_op        = i_op;
                    n_page      = in_page;
                    n_tag       = i_block_tag;
                    n_remaining = i_page_count;
                    n_stored    = phtab_pkg::LEN_ZERO;
                    n_k         = '0;
                    n_idx       = in_page[phtab_pkg::CAP_LOG2-1:0];
                    n_found     = '0;
                    if (zero_insert) begin
                        n_strobe = 1'b1;
                        n_status = phtab_pkg::ST_OK;
                    end
                end
            end
            phtab_pkg::S_CMP: begin
                if (slot_hit || slot_free) begin
                    if (r_op == phtab_pkg::OP_LOOKUP) begin
                        n_strobe = 1'b1;
                        n_status = slot_hit ? phtab_pkg::ST_OK : phtab_pkg::ST_MISS;
                        n_found  = slot_hit ? i_rd_data.tag : '0;
                    end else begin
                        o_req.we = 1'b1;
                        n_stored = r_stored + phtab_pkg::LEN_ONE;
                        if (slot_free) begin
                            n_valid_cnt = r_valid_cnt + phtab_pkg::CNT_ONE;
                        end
                        if (last_page) begin
                            n_strobe = 1'b1;
                            n_status = phtab_pkg::ST_OK;
                        end else begin
                            n_page      = page_inc;
                            n_remaining = r_remaining - phtab_pkg::LEN_ONE;
                            n_k         = '0;
                            n_idx       = page_inc[phtab_pkg::CAP_LOG2-1:0];
                        end
                    end
                end else if (k_last) begin
                    n_strobe = 1'b1;
                    n_status = (r_op == phtab_pkg::OP_LOOKUP)
                               ? phtab_pkg::ST_MISS : phtab_pkg::ST_FULL;
                end else begin
                    n_k   = r_k + phtab_pkg::IDX_ONE;
                    n_idx = idx_sum;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= phtab_pkg::S_CLEAR;
            r_k         <= '0;
            r_idx       <= '0;
            r_valid_cnt <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_idx       <= n_idx;
            r_valid_cnt <= n_valid_cnt;
            r_strobe    <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_page      <= n_page;
        r_tag       <= n_tag;
        r_remaining <= n_remaining;
        r_stored    <= n_stored;
        r_status    <= n_status;
        r_found     <= n_found;
    end

    assign busy           = (r_state != phtab_pkg::S_IDLE);
    assign o_rd_addr      = r_idx;
    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_found_tag    = r_found;
    assign o_pages_stored = r_stored;
    assign o_occupancy    = r_valid_cnt;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid_cnt <= phtab_pkg::CNT_CAP)
        else $error("occupancy above capacity");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_valid_cnt == $past(r_valid_cnt)) ||
                           (r_valid_cnt == $past(r_valid_cnt) + phtab_pkg::CNT_ONE))
        else $error("occupancy moved by more than one");

    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.we |-> (r_state == phtab_pkg::S_CMP) || (r_state == phtab_pkg::S_CLEAR))
        else $error("slot write outside probe or clear");

    a_full_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && (r_status == phtab_pkg::ST_FULL) |-> (r_op == phtab_pkg::OP_INSERT))
        else $error("full status on a lookup");

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_strobe |-> ($past(r_state) == phtab_pkg::S_CMP) ||
                                       ($past(r_state) == phtab_pkg::S_IDLE))
        else $error("result word from wrong state");
`endif

endmodule
